// ===== hw/rtl/bif_pkg.sv =====
package bif_pkg;

    localparam int RADIUS      = 2;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WEIGHT_BITS = 16;

    localparam int SIDE        = 2 * RADIUS + 1;
    localparam int TAPS        = SIDE * SIDE;
    localparam int RING        = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int RANGE_DEPTH = 256;

    localparam int ADDR_W   = $clog2(RING);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int COUNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SIDE_W   = $clog2(SIDE);
    localparam int TAP_W    = $clog2(TAPS);
    localparam int PROD_W   = 2 * WEIGHT_BITS;
    localparam int DEN_W    = PROD_W + $clog2(TAPS + 1);
    localparam int NUM_W    = DEN_W + 8;

    localparam logic [1:0] CMD_PIXEL   = 2'd0;
    localparam logic [1:0] CMD_RANGE   = 2'd1;
    localparam logic [1:0] CMD_SPATIAL = 2'd2;
    localparam logic [1:0] CMD_DRAIN   = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  table_index;
        logic [15:0] weight_value;
        logic [7:0]  pixel;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

// ===== hw/rtl/bif_div.sv =====
module bif_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bif_pkg::NUM_W-1:0]  num,
    input  logic [bif_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [7:0]                 quotient
);

    localparam int RW = bif_pkg::NUM_W + 1;

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] dvs_reg, dvs_next;
    logic [7:0]    quo_reg, quo_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = RW'(num) + RW'(den >> 1);
            dvs_next  = RW'(den) << 7;
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[6:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[6:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/bif_front.sv =====
module bif_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             cmd,
    input  logic [7:0]             table_index,
    input  logic [15:0]            weight_value,
    input  logic [7:0]             pixel,
    output bif_pkg::queue_out_t    q,
    input  logic                   q_take
);

    bif_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    bif_pkg::item_t in_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_take && (count_reg != 2'd0);

    always_comb
    begin
        in_item.cmd          = cmd;
        in_item.table_index  = table_index;
        in_item.weight_value = weight_value;
        in_item.pixel        = pixel;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q.valid = (count_reg != 2'd0);
    assign q.item  = slot_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/bif_back.sv =====
module bif_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic                   cfg_index,
    input  logic [12:0]            cfg_data,
    input  bif_pkg::queue_out_t    q,
    output logic                   q_take,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             mean_pixel,
    output logic                   frame_last,
    output logic                   weight_sum_zero
);

    localparam int AW = bif_pkg::ADDR_W;
    localparam int CW = bif_pkg::COUNT_W;
    localparam int WW = bif_pkg::WIDTH_W;
    localparam int HW = bif_pkg::HEIGHT_W;
    localparam int SW = bif_pkg::SIDE_W;
    localparam int TW = bif_pkg::TAP_W;
    localparam int WB = bif_pkg::WEIGHT_BITS;
    localparam int PW = bif_pkg::PROD_W;
    localparam int DW = bif_pkg::DEN_W;
    localparam int NW = bif_pkg::NUM_W;

    localparam logic [AW-1:0] RING_A   = AW'(bif_pkg::RING);
    localparam logic [AW-1:0] RING_TOP = AW'(bif_pkg::RING - 1);
    localparam logic [SW-1:0] SIDE_TOP = SW'(bif_pkg::SIDE - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTRE = 3'd1;
    localparam logic [2:0] ST_CWAIT  = 3'd2;
    localparam logic [2:0] ST_TAPS   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_DSTART = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [7:0]    line_mem [bif_pkg::RING];
    logic [WB-1:0] rng_mem  [bif_pkg::RANGE_DEPTH];
    logic [WB-1:0] spat_reg [bif_pkg::TAPS];
    logic [bif_pkg::RANGE_DEPTH-1:0] rng_vld_reg;

    logic [2:0]    state_reg, state_next;
    logic [10:0]   cfg_w_reg, cfg_w_next;
    logic [12:0]   cfg_h_reg, cfg_h_next;
    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] op_reg, op_next;
    logic [HW-1:0] orow_reg, orow_next;
    logic [WW-1:0] ocol_reg, ocol_next;
    logic [HW-1:0] e_row_reg, e_row_next;
    logic [WW-1:0] e_col_reg, e_col_next;
    logic          e_last_reg, e_last_next;
    logic [AW-1:0] e_op_reg, e_op_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [AW-1:0] tap_addr_reg, tap_addr_next;
    logic [SW-1:0] tr_reg, tr_next;
    logic [SW-1:0] tc_reg, tc_next;
    logic [TW-1:0] tap_reg, tap_next;
    logic [1:0]    flush_reg, flush_next;
    logic [7:0]    centre_reg, centre_next;
    logic [DW-1:0] den_reg, den_next;
    logic [NW-1:0] num_reg, num_next;

    logic          s1_v_reg, s1_in_reg, s2_v_reg, s3_v_reg;
    logic [TW-1:0] s1_tap_reg, s2_tap_reg;
    logic [7:0]    s2_q_reg, s3_q_reg;
    logic [PW-1:0] s3_wt_reg;
    logic [7:0]    mem_q;
    logic [WB-1:0] rng_q;
    logic          rngv_q;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    pix_reg, pix_next;
    logic          last_reg, last_next;
    logic          zero_reg, zero_next;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [CW-1:0] total, lag, in_inc;
    logic [AW-1:0] rd_addr, rb_init;
    logic          line_we;
    logic [AW:0]   rb_sum;
    logic [AW-1:0] rb_wrap, ta_inc;
    logic [HW:0]   rsum;
    logic [WW:0]   csum;
    logic          tap_in;
    logic [7:0]    s1_q, s1_diff;
    logic [WB-1:0] s2_rw;
    logic [PW+7:0] wq;
    logic          emit;
    logic          div_start, div_done;
    logic [7:0]    div_q;
    logic [WB-1:0] wv;

    always_comb
    begin
        if (cfg_w_reg == 11'd0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(cfg_w_reg) > bif_pkg::MAX_WIDTH)
        begin
            eff_w = WW'(bif_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(cfg_w_reg);
        end
        if (cfg_h_reg == 13'd0)
        begin
            eff_h = HW'(1);
        end
        else if (int'(cfg_h_reg) > bif_pkg::MAX_HEIGHT)
        begin
            eff_h = HW'(bif_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(cfg_h_reg);
        end
    end

    assign total   = CW'(eff_w) * CW'(eff_h);
    assign lag     = CW'(bif_pkg::RADIUS) * CW'(eff_w) + CW'(bif_pkg::RADIUS);
    assign in_inc  = in_cnt_reg + CW'(1);
    assign rb_init = (op_reg >= AW'(lag)) ? op_reg - AW'(lag) : op_reg + RING_A - AW'(lag);
    assign rb_sum  = {1'b0, row_base_reg} + (AW + 1)'(eff_w);
    assign rb_wrap = (rb_sum >= (AW + 1)'(bif_pkg::RING)) ?
                     AW'(rb_sum - (AW + 1)'(bif_pkg::RING)) : AW'(rb_sum);
    assign ta_inc  = (tap_addr_reg == RING_TOP) ? '0 : tap_addr_reg + AW'(1);
    assign rsum    = (HW + 1)'(e_row_reg) + (HW + 1)'(tr_reg);
    assign csum    = (WW + 1)'(e_col_reg) + (WW + 1)'(tc_reg);
    assign tap_in  = (rsum >= (HW + 1)'(bif_pkg::RADIUS))
                  && (rsum < (HW + 1)'(eff_h) + (HW + 1)'(bif_pkg::RADIUS))
                  && (csum >= (WW + 1)'(bif_pkg::RADIUS))
                  && (csum < (WW + 1)'(eff_w) + (WW + 1)'(bif_pkg::RADIUS));
    assign s1_q    = s1_in_reg ? mem_q : 8'd0;
    assign s1_diff = (centre_reg >= s1_q) ? centre_reg - s1_q : s1_q - centre_reg;
    assign s2_rw   = rngv_q ? rng_q : '0;
    assign wq      = (PW + 8)'(s3_wt_reg) * (PW + 8)'(s3_q_reg);
    assign wv      = WB'(q.item.weight_value);
    assign q_take  = (state_reg == ST_IDLE) && q.valid;
    assign div_start = (state_reg == ST_DSTART);

    always_comb
    begin
        state_next    = state_reg;
        cfg_w_next    = cfg_w_reg;
        cfg_h_next    = cfg_h_reg;
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        wp_next       = wp_reg;
        op_next       = op_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        e_row_next    = e_row_reg;
        e_col_next    = e_col_reg;
        e_last_next   = e_last_reg;
        e_op_next     = e_op_reg;
        row_base_next = row_base_reg;
        tap_addr_next = tap_addr_reg;
        tr_next       = tr_reg;
        tc_next       = tc_reg;
        tap_next      = tap_reg;
        flush_next    = flush_reg;
        centre_next   = centre_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        out_valid_next = out_valid_reg && out_stall;
        pix_next      = pix_reg;
        last_next     = last_reg;
        zero_next     = zero_reg;
        line_we       = 1'b0;
        rd_addr       = tap_addr_reg;
        emit          = 1'b0;

        if (s3_v_reg)
        begin
            den_next = den_reg + DW'(s3_wt_reg);
            num_next = num_reg + NW'(wq);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q.valid)
                begin
                    unique case (q.item.cmd)
                        bif_pkg::CMD_PIXEL:
                        begin
                            if (in_cnt_reg < total)
                            begin
                                line_we     = 1'b1;
                                in_cnt_next = in_inc;
                                wp_next     = (wp_reg == RING_TOP) ? '0 : wp_reg + AW'(1);
                                emit = (in_inc > lag) && (out_cnt_reg < total);
                            end
                        end
                        bif_pkg::CMD_DRAIN:
                        begin
                            emit = (in_cnt_reg >= total) && (out_cnt_reg < total);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (emit)
                begin
                    e_op_next     = op_reg;
                    e_row_next    = orow_reg;
                    e_col_next    = ocol_reg;
                    e_last_next   = (out_cnt_reg + CW'(1)) >= total;
                    row_base_next = rb_init;
                    tap_addr_next = rb_init;
                    tr_next       = '0;
                    tc_next       = '0;
                    tap_next      = '0;
                    den_next      = '0;
                    num_next      = '0;
                    state_next    = ST_CENTRE;
                    if ((out_cnt_reg + CW'(1)) >= total)
                    begin
                        out_cnt_next = '0;
                        in_cnt_next  = '0;
                        wp_next      = '0;
                        op_next      = '0;
                        orow_next    = '0;
                        ocol_next    = '0;
                    end
                    else
                    begin
                        out_cnt_next = out_cnt_reg + CW'(1);
                        op_next      = (op_reg == RING_TOP) ? '0 : op_reg + AW'(1);
                        if (ocol_reg + WW'(1) >= eff_w)
                        begin
                            ocol_next = '0;
                            orow_next = orow_reg + HW'(1);
                        end
                        else
                        begin
                            ocol_next = ocol_reg + WW'(1);
                        end
                    end
                end
            end
            ST_CENTRE:
            begin
                rd_addr    = e_op_reg;
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                centre_next = mem_q;
                state_next  = ST_TAPS;
            end
            ST_TAPS:
            begin
                tap_next = tap_reg + TW'(1);
                if (tc_reg == SIDE_TOP)
                begin
                    tc_next       = '0;
                    tr_next       = tr_reg + SW'(1);
                    row_base_next = rb_wrap;
                    tap_addr_next = rb_wrap;
                    if (tr_reg == SIDE_TOP)
                    begin
                        flush_next = 2'd2;
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    tc_next       = tc_reg + SW'(1);
                    tap_addr_next = ta_inc;
                end
            end
            ST_FLUSH:
            begin
                flush_next = flush_reg - 2'd1;
                if (flush_reg == 2'd0)
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pix_next       = (den_reg == '0) ? 8'd0 : div_q;
                    zero_next      = (den_reg == '0);
                    last_next      = e_last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            unique case (cfg_index)
                bif_pkg::CFG_WIDTH:  cfg_w_next = cfg_data[10:0];
                bif_pkg::CFG_HEIGHT: cfg_h_next = cfg_data;
            endcase
            in_cnt_next  = '0;
            out_cnt_next = '0;
            wp_next      = '0;
            op_next      = '0;
            orow_next    = '0;
            ocol_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_w_reg     <= 11'd1024;
            cfg_h_reg     <= 13'd1024;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            wp_reg        <= '0;
            op_reg        <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rng_vld_reg   <= '0;
            for (int i = 0; i < bif_pkg::TAPS; i++)
            begin
                spat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cfg_w_reg     <= cfg_w_next;
            cfg_h_reg     <= cfg_h_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            wp_reg        <= wp_next;
            op_reg        <= op_next;
            orow_reg      <= orow_next;
            ocol_reg      <= ocol_next;
            s1_v_reg      <= (state_reg == ST_TAPS);
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            out_valid_reg <= out_valid_next;
            if (q_take && (q.item.cmd == bif_pkg::CMD_RANGE))
            begin
                rng_vld_reg[q.item.table_index] <= 1'b1;
            end
            if (q_take && (q.item.cmd == bif_pkg::CMD_SPATIAL)
                && (int'(q.item.table_index) < bif_pkg::TAPS))
            begin
                spat_reg[TW'(q.item.table_index)] <= wv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_row_reg    <= e_row_next;
        e_col_reg    <= e_col_next;
        e_last_reg   <= e_last_next;
        e_op_reg     <= e_op_next;
        row_base_reg <= row_base_next;
        tap_addr_reg <= tap_addr_next;
        tr_reg       <= tr_next;
        tc_reg       <= tc_next;
        tap_reg      <= tap_next;
        flush_reg    <= flush_next;
        centre_reg   <= centre_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        pix_reg      <= pix_next;
        last_reg     <= last_next;
        zero_reg     <= zero_next;
        s1_in_reg    <= tap_in;
        s1_tap_reg   <= tap_reg;
        s2_tap_reg   <= s1_tap_reg;
        s2_q_reg     <= s1_q;
        s3_q_reg     <= s2_q_reg;
        s3_wt_reg    <= PW'(s2_rw) * PW'(spat_reg[s2_tap_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[wp_reg] <= q.item.pixel;
        end
        mem_q <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_take && (q.item.cmd == bif_pkg::CMD_RANGE))
        begin
            rng_mem[q.item.table_index] <= wv;
        end
        rng_q  <= rng_mem[s1_diff];
        rngv_q <= rng_vld_reg[s1_diff];
    end

    bif_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid       = out_valid_reg;
    assign mean_pixel      = pix_reg;
    assign frame_last      = last_reg;
    assign weight_sum_zero = zero_reg;

endmodule

// ===== hw/rtl/bilateral_image_filter_top.sv =====
// Bilateral filter for 8-bit gray pixels streamed in raster order.
// Input channel (in_valid/in_stall): cmd selects a pixel, a range weight
// write (table_index = absolute difference), a spatial weight write
// (table_index = tap row * window side + column) or a drain request.
// Output channel (out_valid/out_stall): one filtered pixel per emitting
// item, with frame_last on the final pixel and weight_sum_zero when the
// window weights summed to zero.
// Config port: cfg_write with cfg_index 0 sets frame width, 1 sets frame
// height; any write restarts the frame.
// Output k appears once pixel k + RADIUS*width + RADIUS is in; drain
// items flush the remaining outputs after the last pixel.
// Table writes and non-emitting pixels are handled in the idle state.
// For an emitting item the window taps are read one per cycle through
// the single line-store read port, then an 8-step divider forms the
// mean; no new item is taken from the queue until it is done.
// A two-item queue sits between the input and the back end.
// Reset clears counters, weight tables and both channels; sizes return
// to 1024 x 1024. When out_stall is high the result holds in the output
// register while the back end goes on with the next item.
module bilateral_image_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  table_index,
    input  logic [15:0] weight_value,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mean_pixel,
    output logic        frame_last,
    output logic        weight_sum_zero
);

    bif_pkg::queue_out_t q;
    logic                q_take;

    bif_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .table_index  (table_index),
        .weight_value (weight_value),
        .pixel        (pixel),
        .q            (q),
        .q_take       (q_take)
    );

    bif_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q               (q),
        .q_take          (q_take),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_pixel      (mean_pixel),
        .frame_last      (frame_last),
        .weight_sum_zero (weight_sum_zero)
    );

endmodule

// ===== hw/rtl/bif_checker.sv =====
module bif_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] mean_pixel,
    input logic       frame_last,
    input logic       weight_sum_zero
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && weight_sum_zero |-> mean_pixel == 8'd0)
        else $error("zero weight sum with nonzero pixel");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled item dropped");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(mean_pixel) && $stable(frame_last)
            && $stable(weight_sum_zero))
        else $error("stalled item changed");

endmodule

bind bilateral_image_filter_top bif_checker u_bif_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mean_pixel      (mean_pixel),
    .frame_last      (frame_last),
    .weight_sum_zero (weight_sum_zero)
);
